// ===== rtl/tinterp_pkg.sv =====
package tinterp_pkg;

	localparam int VW      = 32;          // value width, Q16.16
	localparam int DW      = VW + 1;      // width of a difference of two values
	localparam int PW      = 2 * VW + 1;  // width of the product of two magnitudes
	localparam int CNT_W   = $clog2(PW);
	localparam int CFG_W   = 11;
	localparam int TYPE_W  = 2;
	localparam int EIDX_W  = 10;

	localparam logic [TYPE_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_FWD  = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_BACK = 2'd2;

	localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1024;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK0,
		ST_CHK0_W,
		ST_CHKN,
		ST_CHKN_W,
		ST_SRCH,
		ST_SRCH_W,
		ST_PAIR0_W,
		ST_PAIR1_W,
		ST_DIFF,
		ST_PROD,
		ST_DIV,
		ST_FIN,
		ST_PUT
	} state_t;

	typedef enum logic [2:0] {
		RD_ZERO,
		RD_LAST,
		RD_MID,
		RD_LO,
		RD_LO1
	} rd_sel_t;

	typedef struct packed {
		logic    mem_wr;
		logic    latch_req;
		rd_sel_t rd_sel;
		logic    cap_clamp;
		logic    init_search;
		logic    step_search;
		logic    cap_p0;
		logic    cap_p1;
		logic    diff;
		logic    prod;
		logic    div_step;
		logic    fin;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic q_le_key;
		logic q_ge_key;
		logic search_done;
		logic dx_nonpos;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/tinterp_req_if.sv =====
interface tinterp_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [tinterp_pkg::TYPE_W-1:0]         req_type;
	logic [tinterp_pkg::EIDX_W-1:0]         entry_index;
	logic signed [tinterp_pkg::VW-1:0]      entry_source;
	logic signed [tinterp_pkg::VW-1:0]      entry_score;
	logic signed [tinterp_pkg::VW-1:0]      query_value;

	modport source (
		output valid, req_type, entry_index, entry_source, entry_score, query_value,
		input  ready
	);
	modport sink (
		input  valid, req_type, entry_index, entry_source, entry_score, query_value,
		output ready
	);
endinterface

// ===== rtl/tinterp_rsp_if.sv =====
interface tinterp_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [tinterp_pkg::VW-1:0]      result_value;
	logic                                   out_of_range;

	modport source (output valid, result_value, out_of_range, input ready);
	modport sink (input valid, result_value, out_of_range, output ready);
endinterface

// ===== rtl/tinterp_ctrl.sv =====
module tinterp_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic [tinterp_pkg::TYPE_W-1:0] req_type,
	output logic                           req_ready,
	input  tinterp_pkg::sts_t              sts,
	output tinterp_pkg::cmd_t              cmd
);

	tinterp_pkg::state_t state_q, state_nx;
	logic                accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tinterp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign req_ready = (state_q == tinterp_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		cmd.rd_sel = tinterp_pkg::RD_LO;
		case (state_q)
			tinterp_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_type == tinterp_pkg::REQ_LOAD) begin
						cmd.mem_wr = 1'b1;
					end else if (req_type == tinterp_pkg::REQ_FWD ||
						req_type == tinterp_pkg::REQ_BACK) begin
						cmd.latch_req = 1'b1;
						state_nx      = tinterp_pkg::ST_CHK0;
					end
				end
			end
			tinterp_pkg::ST_CHK0: begin
				cmd.rd_sel = tinterp_pkg::RD_ZERO;
				state_nx   = tinterp_pkg::ST_CHK0_W;
			end
			tinterp_pkg::ST_CHK0_W: begin
				if (sts.q_le_key) begin
					cmd.cap_clamp = 1'b1;
					state_nx      = tinterp_pkg::ST_PUT;
				end else begin
					state_nx = tinterp_pkg::ST_CHKN;
				end
			end
			tinterp_pkg::ST_CHKN: begin
				cmd.rd_sel = tinterp_pkg::RD_LAST;
				state_nx   = tinterp_pkg::ST_CHKN_W;
			end
			tinterp_pkg::ST_CHKN_W: begin
				if (sts.q_ge_key) begin
					cmd.cap_clamp = 1'b1;
					state_nx      = tinterp_pkg::ST_PUT;
				end else begin
					cmd.init_search = 1'b1;
					state_nx        = tinterp_pkg::ST_SRCH;
				end
			end
			tinterp_pkg::ST_SRCH: begin
				if (sts.search_done) begin
					cmd.rd_sel = tinterp_pkg::RD_LO;
					state_nx   = tinterp_pkg::ST_PAIR0_W;
				end else begin
					cmd.rd_sel = tinterp_pkg::RD_MID;
					state_nx   = tinterp_pkg::ST_SRCH_W;
				end
			end
			tinterp_pkg::ST_SRCH_W: begin
				cmd.step_search = 1'b1;
				state_nx        = tinterp_pkg::ST_SRCH;
			end
			tinterp_pkg::ST_PAIR0_W: begin
				cmd.cap_p0 = 1'b1;
				cmd.rd_sel = tinterp_pkg::RD_LO1;
				state_nx   = tinterp_pkg::ST_PAIR1_W;
			end
			tinterp_pkg::ST_PAIR1_W: begin
				cmd.cap_p1 = 1'b1;
				state_nx   = tinterp_pkg::ST_DIFF;
			end
			tinterp_pkg::ST_DIFF: begin
				cmd.diff = 1'b1;
				state_nx = tinterp_pkg::ST_PROD;
			end
			tinterp_pkg::ST_PROD: begin
				// zero-width or negative interval: midpoint already sits in the result register
				if (sts.dx_nonpos) begin
					state_nx = tinterp_pkg::ST_PUT;
				end else begin
					cmd.prod = 1'b1;
					state_nx = tinterp_pkg::ST_DIV;
				end
			end
			tinterp_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nx = tinterp_pkg::ST_FIN;
				end
			end
			tinterp_pkg::ST_FIN: begin
				cmd.fin  = 1'b1;
				state_nx = tinterp_pkg::ST_PUT;
			end
			tinterp_pkg::ST_PUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = tinterp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = tinterp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/tinterp_dp.sv =====
module tinterp_dp #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tinterp_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [tinterp_pkg::TYPE_W-1:0]     req_type,
	input  logic [tinterp_pkg::EIDX_W-1:0]     entry_index,
	input  logic signed [tinterp_pkg::VW-1:0]  entry_source,
	input  logic signed [tinterp_pkg::VW-1:0]  entry_score,
	input  logic signed [tinterp_pkg::VW-1:0]  query_value,
	input  tinterp_pkg::cmd_t                  cmd,
	output tinterp_pkg::sts_t                  sts,
	input  logic                               rsp_ready,
	output logic                               rsp_valid,
	output logic signed [tinterp_pkg::VW-1:0]  result_value,
	output logic                               out_of_range
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int VW    = tinterp_pkg::VW;
	localparam int DW    = tinterp_pkg::DW;
	localparam int PW    = tinterp_pkg::PW;
	localparam int SW    = VW + 3;

	localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (VW - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SAT_MIN = SW'(-(64'sd1 <<< (VW - 1)));

	logic signed [VW-1:0] src_mem [TABLE_ENTRIES];
	logic signed [VW-1:0] scr_mem [TABLE_ENTRIES];

	logic [tinterp_pkg::CFG_W-1:0] entries_q;
	logic                          is_back_q;
	logic signed [VW-1:0]          q_q;
	logic [IDX_W-1:0]              last_q, lo_q, hi_q;
	logic signed [VW-1:0]          rd_src_q, rd_scr_q;
	logic signed [VW-1:0]          x0_q, x1_q, y0_q, y1_q;
	logic signed [DW-1:0]          dx_q;
	logic [DW-1:0]                 dymag_q, nummag_q;
	logic                          neg_q;
	logic [PW-1:0]                 quo_q;
	logic [DW:0]                   rem_q;
	logic [tinterp_pkg::CNT_W-1:0] cnt_q;
	logic signed [VW-1:0]          res_q;
	logic                          oor_q;
	logic                          rsp_valid_q;
	logic signed [VW-1:0]          rsp_val_q;
	logic                          rsp_oor_q;

	logic [31:0]          ld_idx_ext;
	logic [IDX_W-1:0]     ld_addr, rd_addr, mid;
	logic                 ld_ok;
	int                   n_clamped;
	logic signed [VW-1:0] key, val;
	logic signed [DW-1:0] dx_w, dy_w, num_w, mid_sum;
	logic signed [DW-1:0] mid_half;
	logic [DW:0]          div_t, div_d;
	logic                 div_ge;
	logic signed [SW-1:0] fin_sum;
	logic signed [VW-1:0] fin_res;

	// load address and the clamped entry count
	assign ld_idx_ext = 32'(entry_index);
	assign ld_addr    = ld_idx_ext[IDX_W-1:0];
	assign ld_ok      = (ld_idx_ext < 32'(TABLE_ENTRIES));

	always_comb begin
		n_clamped = int'(entries_q);
		if (n_clamped < 2) begin
			n_clamped = 2;
		end else if (n_clamped > TABLE_ENTRIES) begin
			n_clamped = TABLE_ENTRIES;
		end
	end

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		case (cmd.rd_sel)
			tinterp_pkg::RD_ZERO: rd_addr = '0;
			tinterp_pkg::RD_LAST: rd_addr = last_q;
			tinterp_pkg::RD_MID:  rd_addr = mid;
			tinterp_pkg::RD_LO1:  rd_addr = lo_q + IDX_W'(1);
			default:              rd_addr = lo_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && ld_ok) begin
			src_mem[ld_addr] <= entry_source;
			scr_mem[ld_addr] <= entry_score;
		end
		rd_src_q <= src_mem[rd_addr];
		rd_scr_q <= scr_mem[rd_addr];
	end

	assign key = is_back_q ? rd_scr_q : rd_src_q;
	assign val = is_back_q ? rd_src_q : rd_scr_q;

	assign dx_w     = DW'(x1_q) - DW'(x0_q);
	assign dy_w     = DW'(y1_q) - DW'(y0_q);
	assign num_w    = DW'(q_q) - DW'(x0_q);
	assign mid_sum  = DW'(y0_q) + DW'(y1_q);
	assign mid_half = (mid_sum + DW'(mid_sum < 0)) >>> 1;

	assign div_d  = {1'b0, dx_q};
	assign div_t  = {rem_q[DW-1:0], quo_q[PW-1]};
	assign div_ge = (div_t >= div_d);

	always_comb begin
		fin_sum = neg_q ? SW'(y0_q) - SW'({1'b0, quo_q[DW-1:0]})
		                : SW'(y0_q) + SW'({1'b0, quo_q[DW-1:0]});
		if (|quo_q[PW-1:DW]) begin
			fin_res = neg_q ? VW'(SAT_MIN) : VW'(SAT_MAX);
		end else if (fin_sum > SAT_MAX) begin
			fin_res = VW'(SAT_MAX);
		end else if (fin_sum < SAT_MIN) begin
			fin_res = VW'(SAT_MIN);
		end else begin
			fin_res = VW'(fin_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q   <= tinterp_pkg::ENTRIES_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				entries_q <= cfg_wdata;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			is_back_q <= (req_type == tinterp_pkg::REQ_BACK);
			q_q       <= query_value;
			last_q    <= IDX_W'(n_clamped - 1);
			oor_q     <= 1'b0;
		end
		if (cmd.cap_clamp) begin
			res_q <= is_back_q ? '0 : val;
			oor_q <= is_back_q;
		end
		if (cmd.init_search) begin
			lo_q <= '0;
			hi_q <= last_q;
		end
		if (cmd.step_search) begin
			if (q_q > key) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.cap_p0) begin
			x0_q <= key;
			y0_q <= val;
		end
		if (cmd.cap_p1) begin
			x1_q <= key;
			y1_q <= val;
		end
		if (cmd.diff) begin
			dx_q     <= dx_w;
			dymag_q  <= dy_w[DW-1] ? DW'(-dy_w) : DW'(dy_w);
			nummag_q <= num_w[DW-1] ? DW'(-num_w) : DW'(num_w);
			neg_q    <= dy_w[DW-1] ^ num_w[DW-1];
			res_q    <= VW'(mid_half);
		end
		if (cmd.prod) begin
			quo_q <= PW'(dymag_q * nummag_q);
			rem_q <= '0;
			cnt_q <= '0;
		end
		// restoring division, one quotient bit per cycle
		if (cmd.div_step) begin
			rem_q <= div_ge ? (div_t - div_d) : div_t;
			quo_q <= {quo_q[PW-2:0], div_ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.fin) begin
			res_q <= fin_res;
		end
		if (cmd.out_load) begin
			rsp_val_q <= res_q;
			rsp_oor_q <= oor_q;
		end
	end

	assign sts.q_le_key    = (q_q <= key);
	assign sts.q_ge_key    = (q_q >= key);
	assign sts.search_done = ((hi_q - lo_q) <= IDX_W'(1));
	assign sts.dx_nonpos   = (dx_q <= 0);
	assign sts.div_last    = (cnt_q == tinterp_pkg::CNT_W'(PW - 1));
	assign sts.out_busy    = rsp_valid_q && !rsp_ready;

	assign rsp_valid    = rsp_valid_q;
	assign result_value = rsp_val_q;
	assign out_of_range = rsp_oor_q;

endmodule

// ===== rtl/table_interpolation_transform_core.sv =====
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   req_type, entry_index, entry_source, entry_score, query_value
// rsp       out  valid/ready   result_value, out_of_range
// cfg       in   cfg_we        cfg_wdata (entries_used)
//
// A load beat is written into the table in the cycle it is accepted. A query that
// clamps at a table end (at or below the first entry, or at or above the last entry)
// goes straight to the output register; an interpolated query runs a binary search
// (each step reads the table memory, then narrows the range) and the 65-step restoring
// divider, which a non-positive interval width skips. One query is in flight at a time;
// a finished result waits in the output register while the next beat is taken.
// Reset clears control state and sets entries_used to 1024; table contents are
// undefined until loaded.
module table_interpolation_transform_core #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tinterp_req_if.sink                   req,
	tinterp_rsp_if.source                 rsp,
	input  logic                          cfg_we,
	input  logic [tinterp_pkg::CFG_W-1:0] cfg_wdata
);

	tinterp_pkg::cmd_t cmd;
	tinterp_pkg::sts_t sts;

	tinterp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tinterp_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_type     (req.req_type),
		.entry_index  (req.entry_index),
		.entry_source (req.entry_source),
		.entry_score  (req.entry_score),
		.query_value  (req.query_value),
		.cmd          (cmd),
		.sts          (sts),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.result_value (rsp.result_value),
		.out_of_range (rsp.out_of_range)
	);

`ifndef SYNTHESIS
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.out_of_range) |-> (rsp.result_value == 0))
		else $error("out-of-range result with nonzero value");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready &&
		 (req.req_type == tinterp_pkg::REQ_FWD || req.req_type == tinterp_pkg::REQ_BACK))
		|=> !req.ready)
		else $error("query beat did not close the input");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.out_load))
		else $error("result appeared without an output load");
`endif

endmodule
